/* design/hlfe_pkg.sv */
`timescale 1ns / 1ps

package hlfe_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TRAIL_W  = 2;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_COUNT = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0]  SYNC_FIRST_RST    = 8'hEF;
  localparam logic [BYTE_W-1:0]  SYNC_SECOND_RST   = 8'h12;
  localparam logic [TRAIL_W-1:0] TRAILER_COUNT_RST = 2'd2;

  // Header bytes seen before the command byte
  localparam logic [SIZE_W-1:0] HDR_BYTES = 9'd2;

  // Result queue depth; must hold the two items of a header completion
  localparam int unsigned OUTQ_DEPTH = 4;

  // Push counts into the result queue
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0]  sync_first;
    logic [BYTE_W-1:0]  sync_second;
    logic [TRAIL_W-1:0] trailer_count;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_first;
    logic              frame_last;
    logic [SIZE_W-1:0] frame_size;
  } out_item_t;

  // Items produced by one accepted input byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

/* design/hlfe_if.sv */
`timescale 1ns / 1ps

// Input byte channel
interface hlfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel
interface hlfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;
  logic [8:0] frame_size;

  modport source (output valid, output out_byte, output frame_first,
                  output frame_last, output frame_size, input ready);
  modport sink   (input valid, input out_byte, input frame_first,
                  input frame_last, input frame_size, output ready);
endinterface

// Configuration write channel
interface hlfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/hlfe_core.sv */
`timescale 1ns / 1ps

module hlfe_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [7:0]                  in_byte,
  input  hlfe_pkg::cfg_t              cfg,
  output hlfe_pkg::push_t             push
);
  import hlfe_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_CMD,
    PH_LEN,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [SIZE_W-1:0]   frame_bytes_r, frame_bytes_nxt;
  logic [BYTE_W-1:0]   left_dec;
  logic                last;
  logic                fwd;

  assign left_dec = bytes_left_r - 8'd1;

  // Frame parser: next state and the items this byte produces
  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    frame_bytes_nxt = frame_bytes_r;
    last            = 1'b0;
    fwd             = 1'b0;
    push            = '0;
    push.count      = PUSH_NONE;

    unique case (phase_r)
      PH_HUNT0: begin
        if (in_byte == cfg.sync_first) phase_nxt = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (in_byte == cfg.sync_second) begin
          push.count             = PUSH_TWO;
          push.item0.out_byte    = cfg.sync_first;
          push.item0.frame_first = 1'b1;
          push.item1.out_byte    = in_byte;
          frame_bytes_nxt        = HDR_BYTES;
          phase_nxt              = PH_CMD;
        end else if (in_byte != cfg.sync_first) begin
          phase_nxt = PH_HUNT0;
        end
      end
      PH_CMD: begin
        fwd             = 1'b1;
        frame_bytes_nxt = HDR_BYTES + 9'd1;
        phase_nxt       = PH_LEN;
      end
      PH_LEN: begin
        fwd             = 1'b1;
        frame_bytes_nxt = HDR_BYTES + 9'd2;
        bytes_left_nxt  = in_byte;
        if (in_byte != '0) begin
          phase_nxt = PH_PAYLOAD;
        end else if (cfg.trailer_count != '0) begin
          bytes_left_nxt = BYTE_W'(cfg.trailer_count);
          phase_nxt      = PH_TRAILER;
        end else begin
          phase_nxt = PH_HUNT0;
          last      = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        fwd             = 1'b1;
        frame_bytes_nxt = frame_bytes_r + 9'd1;
        bytes_left_nxt  = left_dec;
        if (left_dec == '0) begin
          // payload done: trailer sampled here
          if (cfg.trailer_count != '0) begin
            bytes_left_nxt = BYTE_W'(cfg.trailer_count);
            phase_nxt      = PH_TRAILER;
          end else begin
            phase_nxt = PH_HUNT0;
            last      = 1'b1;
          end
        end
      end
      PH_TRAILER: begin
        fwd             = 1'b1;
        frame_bytes_nxt = frame_bytes_r + 9'd1;
        bytes_left_nxt  = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_HUNT0;
          last      = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT0;
      end
    endcase

    // single forwarded frame byte
    if (fwd) begin
      push.count            = PUSH_ONE;
      push.item0.out_byte   = in_byte;
      push.item0.frame_last = last;
      push.item0.frame_size = last ? (frame_bytes_nxt - 9'd1) : '0;
    end
  end

  // Parser state, advanced on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT0;
      bytes_left_r  <= '0;
      frame_bytes_r <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      frame_bytes_r <= frame_bytes_nxt;
    end
  end

endmodule

/* design/hlfe_outq.sv */
`timescale 1ns / 1ps

module hlfe_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  hlfe_pkg::push_t        push,
  output logic                   room,
  output logic                   head_valid,
  output hlfe_pkg::out_item_t    head,
  input  logic                   head_ready
);
  import hlfe_pkg::*;

  localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUTQ_DEPTH + 1);

  out_item_t          mem_r [OUTQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [1:0]         n_push;
  logic               pop;

  assign n_push     = accept ? push.count : PUSH_NONE;
  assign head_valid = (count_r != '0);
  assign pop        = head_valid && head_ready;
  assign head       = mem_r[rd_ptr_r];
  // room for the two items of a header completion
  assign room       = (count_r <= CNT_W'(OUTQ_DEPTH - 2));

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_r + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  // Item storage
  always_ff @(posedge clk) begin
    if (n_push != PUSH_NONE) mem_r[wr_ptr_r] <= push.item0;
    if (n_push == PUSH_TWO)  mem_r[wr_ptr_r + PTR_W'(1)] <= push.item1;
  end

endmodule

/* design/header_length_frame_extractor_top.sv */
`timescale 1ns / 1ps

// Sync-header, length-prefixed frame extractor. Accepts one stream byte per
// cycle and forwards the bytes of each recognized frame (sync header,
// command, length, payload, trailer) with first/last marks and, on the last
// byte, the frame size minus one. Bytes outside a frame are dropped. Each
// forwarded item is written into the result queue when its byte is accepted;
// the byte that completes the sync header produces two items. Items wait in
// a four-entry result queue, and in_port.ready is high while that queue has
// space for two items, so with the output taking one item per cycle the
// block sustains one byte per cycle. Configuration writes are always taken;
// index values past the register list are ignored.
module header_length_frame_extractor_top (
  input  logic      clk,
  input  logic      rst_n,
  hlfe_in_if.sink   in_port,
  hlfe_out_if.source out_port,
  hlfe_cfg_if.sink  cfg_port
);
  import hlfe_pkg::*;

  cfg_t      cfg_r;
  push_t     push;
  out_item_t head;
  logic      room;
  logic      accept;

  // Configuration registers
  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first    <= SYNC_FIRST_RST;
      cfg_r.sync_second   <= SYNC_SECOND_RST;
      cfg_r.trailer_count <= TRAILER_COUNT_RST;
    end else if (cfg_port.valid) begin
      unique case (cfg_port.index)
        CFG_SYNC_FIRST:    cfg_r.sync_first    <= cfg_port.data;
        CFG_SYNC_SECOND:   cfg_r.sync_second   <= cfg_port.data;
        CFG_TRAILER_COUNT: cfg_r.trailer_count <= cfg_port.data[TRAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign in_port.ready = room;
  assign accept        = in_port.valid && room;

  hlfe_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_port.in_byte),
    .cfg     (cfg_r),
    .push    (push)
  );

  hlfe_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .push       (push),
    .room       (room),
    .head_valid (out_port.valid),
    .head       (head),
    .head_ready (out_port.ready)
  );

  // Result payload
  assign out_port.out_byte    = head.out_byte;
  assign out_port.frame_first = head.frame_first;
  assign out_port.frame_last  = head.frame_last;
  assign out_port.frame_size  = head.frame_size;

endmodule

/* test/header_length_frame_extractor_top_tb.sv */
`timescale 1ns / 1ps

module header_length_frame_extractor_top_tb;
  import hlfe_pkg::*;

  // Deframer phases of the prediction
  typedef enum logic [2:0] {
    HUNT_IDLE,
    HUNT_ARMED,
    GET_CMD,
    GET_LEN,
    GET_PAYLOAD,
    GET_TRAILER
  } deframe_phase_t;

  // Register index past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hlfe_in_if  in_if ();
  hlfe_out_if out_if ();
  hlfe_cfg_if cfg_if ();

  header_length_frame_extractor_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if),
    .cfg_port (cfg_if)
  );

  // Predicted deframer state and registers
  cfg_t           model_cfg;
  deframe_phase_t model_phase;
  logic [7:0]     model_left;
  logic [8:0]     model_count;

  // Frame items still owed by the block, oldest first
  out_item_t frame_items_due[$];

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned bytes_sent;
  int unsigned items_seen;
  int unsigned frames_seen;
  int unsigned mismatches;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99, 0) >= out_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic out_item_t make_item(input logic [7:0] b, input logic first,
                                          input logic last, input logic [8:0] size);
    out_item_t it;
    it.out_byte    = b;
    it.frame_first = first;
    it.frame_last  = last;
    it.frame_size  = size;
    return it;
  endfunction

  // Payload done: trailer starts, or the frame ends on this byte
  function automatic logic finish_payload();
    if (model_cfg.trailer_count != '0) begin
      model_left  = {6'd0, model_cfg.trailer_count};
      model_phase = GET_TRAILER;
      return 1'b0;
    end
    model_phase = HUNT_IDLE;
    return 1'b1;
  endfunction

  // Advance the predicted deframer by one accepted byte
  function automatic void predict_byte(input logic [7:0] b);
    logic last;
    logic emit;
    last = 1'b0;
    emit = 1'b1;
    unique case (model_phase)
      HUNT_IDLE: begin
        emit = 1'b0;
        if (b == model_cfg.sync_first) model_phase = HUNT_ARMED;
      end
      HUNT_ARMED: begin
        emit = 1'b0;
        if (b == model_cfg.sync_second) begin
          frame_items_due.push_back(make_item(model_cfg.sync_first, 1'b1, 1'b0, '0));
          frame_items_due.push_back(make_item(b, 1'b0, 1'b0, '0));
          model_count = HDR_BYTES;
          model_phase = GET_CMD;
        end else if (b != model_cfg.sync_first) begin
          model_phase = HUNT_IDLE;
        end
      end
      GET_CMD: begin
        model_count = 9'd3;
        model_phase = GET_LEN;
      end
      GET_LEN: begin
        model_count = 9'd4;
        model_left  = b;
        if (b != 8'd0) model_phase = GET_PAYLOAD;
        else last = finish_payload();
      end
      GET_PAYLOAD: begin
        model_count = model_count + 9'd1;
        model_left  = model_left - 8'd1;
        if (model_left == 8'd0) last = finish_payload();
      end
      GET_TRAILER: begin
        model_count = model_count + 9'd1;
        model_left  = model_left - 8'd1;
        if (model_left == 8'd0) begin
          model_phase = HUNT_IDLE;
          last = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
        model_phase = HUNT_IDLE;
      end
    endcase
    if (emit) begin
      frame_items_due.push_back(make_item(b, 1'b0, last, last ? model_count - 9'd1 : '0));
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = make_item(out_if.out_byte, out_if.frame_first, out_if.frame_last,
                      out_if.frame_size);
      items_seen++;
      if (got.frame_last) frames_seen++;
      if (frame_items_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte %02h", got.out_byte));
      end else begin
        want = frame_items_due.pop_front();
        if (got.out_byte !== want.out_byte || got.frame_first !== want.frame_first ||
            got.frame_last !== want.frame_last || got.frame_size !== want.frame_size) begin
          report_mismatch($sformatf(
            "item %0d got %02h/%b/%b/%0d want %02h/%b/%b/%0d", items_seen,
            got.out_byte, got.frame_first, got.frame_last, got.frame_size,
            want.out_byte, want.frame_first, want.frame_last, want.frame_size));
        end
      end
    end
  end

  // Send one byte, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid   = 1'b1;
    in_if.in_byte = b;
    do @(posedge clk); while (!in_if.ready);
    predict_byte(b);
    bytes_sent++;
  endtask

  // Hold the input until every owed item has arrived and the block settles
  task automatic wait_quiet();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (frame_items_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk); while (!cfg_if.ready);
    unique case (idx)
      CFG_SYNC_FIRST:    model_cfg.sync_first    = val;
      CFG_SYNC_SECOND:   model_cfg.sync_second   = val;
      CFG_TRAILER_COUNT: model_cfg.trailer_count = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] first, input logic [7:0] second,
                            input logic [7:0] trailer);
    wait_quiet();
    write_reg(CFG_SYNC_FIRST, first);
    write_reg(CFG_SYNC_SECOND, second);
    write_reg(CFG_TRAILER_COUNT, trailer);
  endtask

  // Well-formed frame under the current registers
  task automatic send_frame(input int unsigned len);
    send_byte(model_cfg.sync_first);
    send_byte(model_cfg.sync_second);
    send_byte(8'($urandom_range(255, 0)));
    send_byte(len[7:0]);
    repeat (len) send_byte(8'($urandom_range(255, 0)));
    repeat (model_cfg.trailer_count) send_byte(8'($urandom_range(255, 0)));
  endtask

  // Mostly frames, with noise, broken headers, cut frames and drain pauses
  task automatic run_random_traffic(input int unsigned quota, input bit with_max_frame);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    if (with_max_frame) send_frame(255);
    while (bytes_sent - start < quota) begin
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        send_frame($urandom_range(12, 0));
      end else if (pick < 73) begin
        send_frame($urandom_range(255, 0));
      end else if (pick < 83) begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255, 0)));
      end else if (pick < 90) begin
        send_byte(model_cfg.sync_first);
        send_byte(8'($urandom_range(255, 0)));
      end else if (pick < 96) begin
        // cut short: the following bytes continue this frame
        send_byte(model_cfg.sync_first);
        send_byte(model_cfg.sync_second);
        send_byte(8'($urandom_range(255, 0)));
        send_byte(8'($urandom_range(8, 1)));
      end else begin
        wait_quiet();
      end
    end
  endtask

  // Short directed frames under reset and hand-picked registers
  task automatic test_directed_frames();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    // armed hunt dropped, repeated first sync byte, empty payload, reset trailer
    send_byte(8'h00);
    send_byte(8'hEF);
    send_byte(8'h00);
    send_byte(8'hEF);
    send_byte(8'hEF);
    send_byte(8'h12);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h55);
    // out-of-range index is ignored; no trailer, empty payload ends on length
    wait_quiet();
    write_reg(CFG_UNMAPPED, 8'hFF);
    write_reg(CFG_TRAILER_COUNT, 8'd0);
    send_byte(8'hEF);
    send_byte(8'h12);
    send_byte(8'h00);
    send_byte(8'h00);
    // no trailer, frame ends on the payload byte
    send_byte(8'hEF);
    send_byte(8'h12);
    send_byte(8'h5A);
    send_byte(8'h01);
    send_byte(8'hFF);
    // equal sync bytes
    set_config(8'hFF, 8'hFF, 8'd1);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h80);
  endtask

  // Register extremes and a maximum-length frame, receiver mostly stalled
  task automatic test_receiver_backpressure();
    in_idle_pct  = 15;
    out_idle_pct = 73;
    set_config(8'h00, 8'hFF, 8'd3);
    run_random_traffic(300, 1'b1);
  endtask

  // Random registers, sender mostly idle
  task automatic test_sender_starved();
    in_idle_pct  = 73;
    out_idle_pct = 15;
    set_config(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
               8'($urandom_range(3, 0)));
    run_random_traffic(300, 1'b0);
  endtask

  // Equal sync bytes, no trailer, full rate
  task automatic test_full_rate();
    logic [7:0] sync_byte;
    sync_byte    = 8'($urandom_range(255, 0));
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_config(sync_byte, sync_byte, 8'd0);
    run_random_traffic(300, 1'b0);
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    model_cfg.sync_first    = SYNC_FIRST_RST;
    model_cfg.sync_second   = SYNC_SECOND_RST;
    model_cfg.trailer_count = TRAILER_COUNT_RST;
    model_phase  = HUNT_IDLE;
    model_left   = '0;
    model_count  = '0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    bytes_sent   = 0;
    items_seen   = 0;
    frames_seen  = 0;
    mismatches   = 0;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_receiver_backpressure();
    test_sender_starved();
    test_full_rate();

    wait_quiet();
    repeat (10) @(posedge clk);

    $display("tb: %0d bytes sent, %0d frame items checked across %0d frames",
             bytes_sent, items_seen, frames_seen);
    $display("tb: covered reset and extreme registers, repeated/equal sync, empty to 255 payload");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
design/hlfe_pkg.sv
design/hlfe_if.sv
design/hlfe_core.sv
design/hlfe_outq.sv
design/header_length_frame_extractor_top.sv
test/header_length_frame_extractor_top_tb.sv
